// ----- design/abm_pkg.sv -----
`timescale 1ns / 1ps

package abm_pkg;

    localparam int ADDR_W     = 32;
    localparam int MAX_RANGES = 1024;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ENTRY_W    = 2 * ADDR_W;

    localparam logic [ADDR_W-1:0] ADDR_MAX   = {ADDR_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(MAX_RANGES);

    // Register index decoded from paddr[2].
    localparam logic REG_TOP_ADDRESS = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DECIDE,
        ST_INS_RD,
        ST_INS_WR,
        ST_COL_RD,
        ST_COL_WR,
        ST_WALK_INIT,
        ST_WALK_RD,
        ST_WALK_CHK
    } state_t;

    typedef enum logic {
        RD_IDX,
        RD_IDX_M1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SHIFT_UP,
        WR_NEW,
        WR_MERGE,
        WR_SHIFT_DN
    } wr_sel_t;

    typedef struct packed {
        logic    accept;
        logic    scan_upd;
        logic    scan_end;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_load_count;
        logic    idx_load_lj1;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    mem_wr;
        wr_sel_t wr_sel;
        logic    count_inc;
        logic    count_sub;
        logic    set_rej;
        logic    walk_init;
        logic    walk_upd;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic rejected;
        logic idx_eq_count;
        logic both_found;
        logic same_pos;
        logic pos_inside;
        logic table_full;
        logic gone_nz;
        logic idx_eq_at;
    } stat_t;

endpackage

// ----- design/abm_ram.sv -----
`timescale 1ns / 1ps

module abm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/abm_ctrl.sv -----
`timescale 1ns / 1ps

module abm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  abm_pkg::stat_t stat,
    output abm_pkg::cmd_t  cmd
);

    abm_pkg::state_t state_reg;
    abm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= abm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = abm_pkg::RD_IDX;
        cmd.wr_sel = abm_pkg::WR_SHIFT_UP;
        s_tready   = 1'b0;
        unique case (state_reg)
            abm_pkg::ST_IDLE:
            begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free)
                begin
                    cmd.accept = 1'b1;
                    state_next = abm_pkg::ST_SCAN_RD;
                end
            end
            abm_pkg::ST_SCAN_RD:
            begin
                if (stat.rejected)
                begin
                    state_next = abm_pkg::ST_WALK_INIT;
                end
                else if (stat.both_found || stat.idx_eq_count)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = abm_pkg::ST_DECIDE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = abm_pkg::ST_SCAN_CHK;
                end
            end
            abm_pkg::ST_SCAN_CHK:
            begin
                cmd.scan_upd = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = abm_pkg::ST_SCAN_RD;
            end
            abm_pkg::ST_DECIDE:
            begin
                if (stat.same_pos)
                begin
                    if (stat.pos_inside)
                    begin
                        state_next = abm_pkg::ST_WALK_INIT;
                    end
                    else if (stat.table_full)
                    begin
                        cmd.set_rej = 1'b1;
                        state_next  = abm_pkg::ST_WALK_INIT;
                    end
                    else
                    begin
                        cmd.idx_load_count = 1'b1;
                        state_next         = abm_pkg::ST_INS_RD;
                    end
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_sel = abm_pkg::WR_MERGE;
                    if (stat.gone_nz)
                    begin
                        cmd.idx_load_lj1 = 1'b1;
                        state_next       = abm_pkg::ST_COL_RD;
                    end
                    else
                    begin
                        state_next = abm_pkg::ST_WALK_INIT;
                    end
                end
            end
            abm_pkg::ST_INS_RD:
            begin
                if (stat.idx_eq_at)
                begin
                    cmd.mem_wr    = 1'b1;
                    cmd.wr_sel    = abm_pkg::WR_NEW;
                    cmd.count_inc = 1'b1;
                    state_next    = abm_pkg::ST_WALK_INIT;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = abm_pkg::RD_IDX_M1;
                    state_next = abm_pkg::ST_INS_WR;
                end
            end
            abm_pkg::ST_INS_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = abm_pkg::WR_SHIFT_UP;
                cmd.idx_dec = 1'b1;
                state_next  = abm_pkg::ST_INS_RD;
            end
            abm_pkg::ST_COL_RD:
            begin
                if (stat.idx_eq_count)
                begin
                    cmd.count_sub = 1'b1;
                    state_next    = abm_pkg::ST_WALK_INIT;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = abm_pkg::ST_COL_WR;
                end
            end
            abm_pkg::ST_COL_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = abm_pkg::WR_SHIFT_DN;
                cmd.idx_inc = 1'b1;
                state_next  = abm_pkg::ST_COL_RD;
            end
            abm_pkg::ST_WALK_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = abm_pkg::ST_WALK_RD;
            end
            abm_pkg::ST_WALK_RD:
            begin
                if (stat.idx_eq_count)
                begin
                    cmd.finish = 1'b1;
                    state_next = abm_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = abm_pkg::ST_WALK_CHK;
                end
            end
            abm_pkg::ST_WALK_CHK:
            begin
                cmd.walk_upd = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = abm_pkg::ST_WALK_RD;
            end
            default:
            begin
                state_next = abm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/abm_datapath.sv -----
`timescale 1ns / 1ps

module abm_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  abm_pkg::cmd_t                cmd,
    output abm_pkg::stat_t               stat,
    input  logic [abm_pkg::ADDR_W-1:0]   in_low,
    input  logic [abm_pkg::ADDR_W-1:0]   in_high,
    input  logic [abm_pkg::ADDR_W-1:0]   top_address,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [abm_pkg::ADDR_W-1:0]   lowest_free,
    output logic                         all_blocked,
    output logic [abm_pkg::ADDR_W:0]     free_count,
    output logic                         rejected
);

    localparam int AW = abm_pkg::ADDR_W;
    localparam int CW = abm_pkg::CNT_W;
    localparam int IW = abm_pkg::IDX_W;

    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next, count_reg, count_next;
    logic          pa_found_reg, pa_found_next, pb_found_reg, pb_found_next;
    logic          pa_in_reg, pa_in_next, pb_in_reg, pb_in_next;
    logic [CW-1:0] pa_idx_reg, pa_idx_next, pb_idx_reg, pb_idx_next;
    logic [AW-1:0] fi_lo_reg, fi_lo_next, fi_hi_reg, fi_hi_next;
    logic [AW-1:0] lj_hi_reg, lj_hi_next, prev_hi_reg, prev_hi_next;
    logic          rej_reg, rej_next;
    logic [AW-1:0] ip_reg, ip_next;
    logic          ip_done_reg, ip_done_next, exh_reg, exh_next;
    logic [AW:0]   gap_next_reg, gap_next_next, cnt_reg, cnt_next;
    logic          gap_done_reg, gap_done_next;
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_low_reg, out_low_next;
    logic          out_blk_reg, out_blk_next, out_rej_reg, out_rej_next;
    logic [AW:0]   out_cnt_reg, out_cnt_next;

    logic [abm_pkg::ENTRY_W-1:0] rdata, wdata;
    logic [IW-1:0] raddr, waddr;
    logic [AW-1:0] ent_lo, ent_hi;
    logic [CW-1:0] lj, gone;
    logic [AW:0]   top1, gap_end, ent_hi1, tail;
    logic [AW-1:0] new_hi, new_lo;
    logic          blocked;

    assign ent_lo = rdata[AW-1:0];
    assign ent_hi = rdata[2*AW-1:AW];

    assign lj   = pb_in_reg ? pb_idx_reg : (pb_idx_reg - CW'(1));
    assign gone = lj - pa_idx_reg;

    assign top1    = {1'b0, top_address} + (AW+1)'(1);
    assign ent_hi1 = {1'b0, ent_hi} + (AW+1)'(1);
    assign gap_end = ({1'b0, ent_lo} < top1) ? {1'b0, ent_lo} : top1;

    // The merged entry spans the new range and both end entries.
    always_comb
    begin
        new_hi = hi_reg;
        if (lj_hi_reg > new_hi)
        begin
            new_hi = lj_hi_reg;
        end
        if (fi_hi_reg > new_hi)
        begin
            new_hi = fi_hi_reg;
        end
        new_lo = (lo_reg < fi_lo_reg) ? lo_reg : fi_lo_reg;
    end

    always_comb
    begin
        raddr = idx_reg[IW-1:0];
        if (cmd.rd_sel == abm_pkg::RD_IDX_M1)
        begin
            raddr = IW'(idx_reg - CW'(1));
        end
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            abm_pkg::WR_SHIFT_UP:
            begin
                waddr = idx_reg[IW-1:0];
                wdata = rdata;
            end
            abm_pkg::WR_NEW:
            begin
                waddr = pa_idx_reg[IW-1:0];
                wdata = {hi_reg, lo_reg};
            end
            abm_pkg::WR_MERGE:
            begin
                waddr = pa_idx_reg[IW-1:0];
                wdata = {new_hi, new_lo};
            end
            abm_pkg::WR_SHIFT_DN:
            begin
                waddr = IW'(idx_reg - gone);
                wdata = rdata;
            end
            default:
            begin
                waddr = idx_reg[IW-1:0];
                wdata = rdata;
            end
        endcase
    end

    abm_ram #(
        .WIDTH (abm_pkg::ENTRY_W),
        .DEPTH (abm_pkg::MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.mem_wr),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.mem_rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.rejected     = rej_reg;
    assign stat.idx_eq_count = (idx_reg == count_reg);
    assign stat.both_found   = pa_found_reg && pb_found_reg;
    assign stat.same_pos     = (pa_idx_reg == pb_idx_reg) && (pa_in_reg == pb_in_reg);
    assign stat.pos_inside   = pa_in_reg;
    assign stat.table_full   = (count_reg >= abm_pkg::COUNT_FULL);
    assign stat.gone_nz      = (gone != '0);
    assign stat.idx_eq_at    = (idx_reg == pa_idx_reg);

    assign tail    = ({1'b0, top_address} >= gap_next_reg) ? (top1 - gap_next_reg) : '0;
    assign blocked = exh_reg || (ip_reg > top_address);

    always_comb
    begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pa_found_next  = pa_found_reg;
        pb_found_next  = pb_found_reg;
        pa_in_next     = pa_in_reg;
        pb_in_next     = pb_in_reg;
        pa_idx_next    = pa_idx_reg;
        pb_idx_next    = pb_idx_reg;
        fi_lo_next     = fi_lo_reg;
        fi_hi_next     = fi_hi_reg;
        lj_hi_next     = lj_hi_reg;
        prev_hi_next   = prev_hi_reg;
        rej_next       = rej_reg;
        ip_next        = ip_reg;
        ip_done_next   = ip_done_reg;
        exh_next       = exh_reg;
        gap_next_next  = gap_next_reg;
        gap_done_next  = gap_done_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_low_next   = out_low_reg;
        out_blk_next   = out_blk_reg;
        out_cnt_next   = out_cnt_reg;
        out_rej_next   = out_rej_reg;

        if (cmd.accept)
        begin
            lo_next       = in_low;
            hi_next       = in_high;
            idx_next      = '0;
            pa_found_next = 1'b0;
            pb_found_next = 1'b0;
            rej_next      = (in_low > in_high);
        end

        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.idx_dec)
        begin
            idx_next = idx_reg - CW'(1);
        end
        if (cmd.idx_load_count)
        begin
            idx_next = count_reg;
        end
        if (cmd.idx_load_lj1)
        begin
            idx_next = lj + CW'(1);
        end

        // One table entry per visit: place both range ends.
        if (cmd.scan_upd)
        begin
            if (!pa_found_reg)
            begin
                if ((lo_reg < ent_lo) || (lo_reg <= ent_hi))
                begin
                    pa_found_next = 1'b1;
                    pa_in_next    = !(lo_reg < ent_lo);
                    pa_idx_next   = idx_reg;
                    fi_lo_next    = ent_lo;
                    fi_hi_next    = ent_hi;
                end
            end
            if (!pb_found_reg)
            begin
                if (hi_reg < ent_lo)
                begin
                    pb_found_next = 1'b1;
                    pb_in_next    = 1'b0;
                    pb_idx_next   = idx_reg;
                    lj_hi_next    = prev_hi_reg;
                end
                else if (hi_reg <= ent_hi)
                begin
                    pb_found_next = 1'b1;
                    pb_in_next    = 1'b1;
                    pb_idx_next   = idx_reg;
                    lj_hi_next    = ent_hi;
                end
            end
            prev_hi_next = ent_hi;
        end

        // An end past the last entry lies in the gap after the table.
        if (cmd.scan_end)
        begin
            if (!pa_found_reg)
            begin
                pa_found_next = 1'b1;
                pa_in_next    = 1'b0;
                pa_idx_next   = count_reg;
            end
            if (!pb_found_reg)
            begin
                pb_found_next = 1'b1;
                pb_in_next    = 1'b0;
                pb_idx_next   = count_reg;
                lj_hi_next    = prev_hi_reg;
            end
        end

        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.count_sub)
        begin
            count_next = count_reg - gone;
        end
        if (cmd.set_rej)
        begin
            rej_next = 1'b1;
        end

        if (cmd.walk_init)
        begin
            idx_next      = '0;
            ip_next       = '0;
            ip_done_next  = 1'b0;
            exh_next      = 1'b0;
            gap_next_next = '0;
            gap_done_next = 1'b0;
            cnt_next      = '0;
        end

        if (cmd.walk_upd)
        begin
            if (!ip_done_reg)
            begin
                if (ip_reg < ent_lo)
                begin
                    ip_done_next = 1'b1;
                end
                else if (ip_reg <= ent_hi)
                begin
                    if (ent_hi == abm_pkg::ADDR_MAX)
                    begin
                        exh_next     = 1'b1;
                        ip_done_next = 1'b1;
                    end
                    else
                    begin
                        ip_next = ent_hi + AW'(1);
                    end
                end
            end
            if (!gap_done_reg)
            begin
                if (gap_next_reg > {1'b0, top_address})
                begin
                    gap_done_next = 1'b1;
                end
                else
                begin
                    if (gap_end > gap_next_reg)
                    begin
                        cnt_next = cnt_reg + (gap_end - gap_next_reg);
                    end
                    if (ent_hi1 > gap_next_reg)
                    begin
                        gap_next_next = ent_hi1;
                    end
                end
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_low_next   = blocked ? '0 : ip_reg;
            out_blk_next   = blocked;
            out_cnt_next   = cnt_reg + tail;
            out_rej_next   = rej_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx_reg      <= idx_next;
        pa_found_reg <= pa_found_next;
        pb_found_reg <= pb_found_next;
        pa_in_reg    <= pa_in_next;
        pb_in_reg    <= pb_in_next;
        pa_idx_reg   <= pa_idx_next;
        pb_idx_reg   <= pb_idx_next;
        fi_lo_reg    <= fi_lo_next;
        fi_hi_reg    <= fi_hi_next;
        lj_hi_reg    <= lj_hi_next;
        prev_hi_reg  <= prev_hi_next;
        rej_reg      <= rej_next;
        ip_reg       <= ip_next;
        ip_done_reg  <= ip_done_next;
        exh_reg      <= exh_next;
        gap_next_reg <= gap_next_next;
        gap_done_reg <= gap_done_next;
        cnt_reg      <= cnt_next;
        out_low_reg  <= out_low_next;
        out_blk_reg  <= out_blk_next;
        out_cnt_reg  <= out_cnt_next;
        out_rej_reg  <= out_rej_next;
    end

    assign out_valid   = out_valid_reg;
    assign lowest_free = out_low_reg;
    assign all_blocked = out_blk_reg;
    assign free_count  = out_cnt_reg;
    assign rejected    = out_rej_reg;

endmodule

// ----- design/address_range_blocklist_merge.sv -----
`timescale 1ns / 1ps

// Blocked address range merger. Each input transfer offers one inclusive
// range; the block keeps up to 1024 sorted, disjoint ranges in a table memory
// and merges, inserts or ignores the new range. Touching ranges stay separate
// entries. A range with low above high, or one that needs a new entry while
// the table is full, is dropped and flagged as rejected. Every input produces
// exactly one output transfer giving the lowest free address (zero and
// all_blocked set when nothing up to top_address is free), the number of free
// addresses in 0..top_address, and the rejected flag. One item is handled at
// a time. The block first places the two range ends by visiting entries in
// order, stopping at the first entry that holds or lies past range_high, then
// may insert or collapse entries by moving them, and then walks the table to
// total the gaps; a range with low above high skips placing. Each visit or
// move reads the table memory, whose read data is registered. After the
// result the block returns to idle, where it takes the next input only once
// the output register is empty or is being read in that same cycle. The user
// must write top_address over the APB port only while the block is idle; the
// block itself does not enforce this.

module address_range_blocklist_merge (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] range_low, [63:32] range_high
    input  logic [63:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] lowest_free, [32] all_blocked, [65:33] free_count,
    // [66] rejected, [71:67] zero
    output logic [71:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = abm_pkg::ADDR_W;

    logic [AW-1:0] top_reg;
    logic [AW-1:0] top_next;

    abm_pkg::cmd_t  cmd;
    abm_pkg::stat_t stat;

    logic [AW-1:0] lowest_free;
    logic          all_blocked;
    logic [AW:0]   free_count;
    logic          rejected;

    // The configuration register takes the write in the access phase.
    assign pready = 1'b1;

    always_comb
    begin
        top_next = top_reg;
        if (psel && penable && pwrite && (paddr[2] == abm_pkg::REG_TOP_ADDRESS))
        begin
            top_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= abm_pkg::ADDR_MAX;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    assign prdata = (paddr[2] == abm_pkg::REG_TOP_ADDRESS) ? top_reg : '0;

    abm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    abm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_low      (s_tdata[31:0]),
        .in_high     (s_tdata[63:32]),
        .top_address (top_reg),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .lowest_free (lowest_free),
        .all_blocked (all_blocked),
        .free_count  (free_count),
        .rejected    (rejected)
    );

    assign m_tdata = {5'b0, rejected, free_count, all_blocked, lowest_free};

endmodule
